// File: rtl/miller_rabin_witness_test_core_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef MILLER_RABIN_WITNESS_TEST_CORE_ASSERT_SVH
`define MILLER_RABIN_WITNESS_TEST_CORE_ASSERT_SVH

// Expression that must hold at every clock edge outside reset.
`define MRWT_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define MRWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mrwt_pkg.sv
package mrwt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_MUL,
    ST_LOOP,
    ST_DONE
  } state_e;

  // What a finished modular multiplication feeds next.
  typedef enum logic [1:0] {
    PH_RED,
    PH_SQ,
    PH_BASE,
    PH_CHK
  } phase_e;

  localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
  localparam logic [1:0] VERDICT_PRIME     = 2'd1;
  localparam logic [1:0] VERDICT_INVALID   = 2'd2;

endpackage

// File: rtl/miller_rabin_witness_test_core.sv
// One Miller-Rabin round on a WIDTH-bit odd modulus held in a configuration
// register (reset value 3); it is to be written through cfg_we_i/cfg_wdata_i
// only while idle, a rule for the user that the block does not enforce.
// Each request carries a witness base and yields one verdict: 0 composite,
// 1 probable prime, 2 invalid modulus (even or below three). The block works
// on one request at a time. All arithmetic runs through a single bit-serial
// modular multiplier that consumes one bit of its second operand per cycle.
// A request reduces the base, splits modulus-1 into 2^k*q, runs WIDTH
// squarings plus one multiplication per set bit of q back to back, then up
// to k squarings in the final check loop, each with a compare, and hands
// the verdict over. With an invalid modulus the block skips the arithmetic
// and goes straight to the done state, which registers the verdict. A
// finished verdict waits in an output register, so the next request is
// taken while it is still stalled.
module miller_rabin_witness_test_core
  import mrwt_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] base_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o
);

  localparam int CW = $clog2(WIDTH);
  localparam int KW = $clog2(WIDTH + 1);
  localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] q_q, q_d;        // modulus-1, then the exponent shifted out
  logic [KW-1:0]    k_q, k_d;
  logic [KW-1:0]    i_q, i_d;
  logic [CW-1:0]    ecnt_q, ecnt_d;  // exponent bits still to scan
  logic [CW-1:0]    mcnt_q, mcnt_d;  // multiplier bits still to scan
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] br_q, br_d;      // reduced base
  logic [WIDTH-1:0] ma_q, ma_d;
  logic [WIDTH-1:0] mb_q, mb_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [1:0]       res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       verdict_q, verdict_d;

  logic             accept;
  logic             mod_bad;
  logic [WIDTH-1:0] m1;
  logic [WIDTH:0]   dbl, dsub, sum, ssub;
  logic [WIDTH-1:0] dmod, step;

  assign accept  = in_valid_i && !in_stall_o;
  assign mod_bad = (mod_q < WIDTH'(3)) || !mod_q[0];
  assign m1      = mod_q - WIDTH'(1);

  // One multiplier step: acc = 2*acc mod m, then add ma when the bit is set.
  always_comb begin
    dbl  = {acc_q, 1'b0};
    dsub = dbl - {1'b0, mod_q};
    dmod = (dbl >= {1'b0, mod_q}) ? dsub[WIDTH-1:0] : dbl[WIDTH-1:0];
    sum  = {1'b0, dmod} + {1'b0, ma_q};
    ssub = sum - {1'b0, mod_q};
    if (mb_q[WIDTH-1]) begin
      step = (sum >= {1'b0, mod_q}) ? ssub[WIDTH-1:0] : sum[WIDTH-1:0];
    end else begin
      step = dmod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_RED;
      mod_q       <= WIDTH'(3);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i[WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q       <= q_d;
    k_q       <= k_d;
    i_q       <= i_d;
    ecnt_q    <= ecnt_d;
    mcnt_q    <= mcnt_d;
    r_q       <= r_d;
    br_q      <= br_d;
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
    verdict_q <= verdict_d;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    q_d         = q_q;
    k_d         = k_q;
    i_d         = i_q;
    ecnt_d      = ecnt_q;
    mcnt_d      = mcnt_q;
    r_d         = r_q;
    br_d        = br_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    acc_d       = acc_q;
    res_d       = res_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mod_bad) begin
            res_d   = VERDICT_INVALID;
            state_d = ST_DONE;
          end else begin
            // Reduce the base as the product 1 * base mod m.
            q_d     = m1;
            k_d     = '0;
            ma_d    = WIDTH'(1);
            mb_d    = base_i[WIDTH-1:0];
            acc_d   = '0;
            mcnt_d  = LAST_BIT;
            phase_d = PH_RED;
            state_d = ST_MUL;
          end
        end
      end
      ST_SPLIT: begin
        if (!q_q[0]) begin
          q_d = q_q >> 1;
          k_d = k_q + KW'(1);
        end else begin
          // Start the exponentiation with r = 1 and a square of it.
          r_d     = WIDTH'(1);
          ecnt_d  = LAST_BIT;
          ma_d    = WIDTH'(1);
          mb_d    = WIDTH'(1);
          acc_d   = '0;
          mcnt_d  = LAST_BIT;
          phase_d = PH_SQ;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_d  = step;
        mb_d   = mb_q << 1;
        mcnt_d = mcnt_q - CW'(1);
        if (mcnt_q == '0) begin
          acc_d  = '0;
          mcnt_d = LAST_BIT;
          case (phase_q)
            PH_RED: begin
              br_d    = step;
              state_d = ST_SPLIT;
            end
            PH_SQ, PH_BASE: begin
              r_d = step;
              if (phase_q == PH_SQ && q_q[WIDTH-1]) begin
                ma_d    = step;
                mb_d    = br_q;
                phase_d = PH_BASE;
              end else if (ecnt_q == '0) begin
                i_d     = '0;
                state_d = ST_LOOP;
                if (step == WIDTH'(1)) begin
                  res_d   = VERDICT_PRIME;
                  state_d = ST_DONE;
                end
              end else begin
                ecnt_d  = ecnt_q - CW'(1);
                q_d     = q_q << 1;
                ma_d    = step;
                mb_d    = step;
                phase_d = PH_SQ;
              end
            end
            PH_CHK: begin
              r_d     = step;
              i_d     = i_q + KW'(1);
              state_d = ST_LOOP;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOP: begin
        if (i_q == k_q) begin
          res_d   = VERDICT_COMPOSITE;
          state_d = ST_DONE;
        end else if (r_q == m1) begin
          res_d   = VERDICT_PRIME;
          state_d = ST_DONE;
        end else begin
          ma_d    = r_q;
          mb_d    = r_q;
          acc_d   = '0;
          mcnt_d  = LAST_BIT;
          phase_d = PH_CHK;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          verdict_d   = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

// File: rtl/mrwt_chk.sv
`include "miller_rabin_witness_test_core_assert.svh"

module mrwt_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] verdict_o
);

  `MRWT_ASSERT_ALWAYS(a_verdict_code, !out_valid_o || verdict_o != 2'd3, "bad verdict code")
  `MRWT_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "not busy after request")
  `MRWT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(verdict_o), "stalled result changed")
  `MRWT_ASSERT_NEXT(a_no_result_idle, !out_valid_o && !in_stall_o, !out_valid_o, "result without request")

endmodule

bind miller_rabin_witness_test_core mrwt_chk u_mrwt_chk (.*);
